/* rtl/utf8vs_pkg.sv */
// ----------------------------------------------------------------------------
// utf8vs_pkg
// Shared widths, byte constants, flaw and verdict codes, and the byte
// sanitizer for the UTF-8 validate and sanitize stream.
// ----------------------------------------------------------------------------
package utf8vs_pkg;

	localparam int CNT_W = 32;
	localparam int SUM_W = ((CNT_W > 32) ? CNT_W : 32) + 1;

	localparam logic [CNT_W-1:0] CNT_CEIL = '1;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_SO    = 8'h0E;
	localparam logic [7:0] CH_SI    = 8'h0F;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CTRL_MAX = 8'h1F;

	localparam logic [7:0] LEAD_C1 = 8'hC1;
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] CONT_A0 = 8'hA0;
	localparam logic [7:0] CONT_90 = 8'h90;
	localparam logic [7:0] CONT_8F = 8'h8F;

	typedef logic [1:0] flaw_t;
	localparam flaw_t FLAW_NONE     = 2'd0;
	localparam flaw_t FLAW_BADCONT  = 2'd1;
	localparam flaw_t FLAW_OVERLONG = 2'd2;
	localparam flaw_t FLAW_RANGE    = 2'd3;

	typedef logic [2:0] verdict_t;
	localparam verdict_t VERD_OK       = 3'd0;
	localparam verdict_t VERD_SIZE     = 3'd1;
	localparam verdict_t VERD_BADLEAD  = 3'd2;
	localparam verdict_t VERD_TRUNC    = 3'd3;
	localparam verdict_t VERD_BADCONT  = 3'd4;
	localparam verdict_t VERD_OVERLONG = 3'd5;
	localparam verdict_t VERD_RANGE    = 3'd6;
	localparam verdict_t VERD_LINES    = 3'd7;

	typedef enum logic [1:0] {
		CFG_MAX_TOTAL   = 2'd0,
		CFG_MAX_LINES   = 2'd1,
		CFG_STRICT      = 2'd2,
		CFG_ALLOW_CTRL  = 2'd3
	} cfg_idx_t;

	function automatic logic [7:0] sanitize(input logic [7:0] b, input logic allow_ctrl);
		logic [7:0] r;
		r = b;
		if (b == CH_ESC || b == CH_BEL || b == CH_SO || b == CH_SI || b == CH_DEL) begin
			r = CH_QMARK;
		end else if (!allow_ctrl && b <= CH_CTRL_MAX && b != CH_LF && b != CH_TAB
				&& b != CH_CR) begin
			r = CH_SPACE;
		end
		return r;
	endfunction

endpackage

/* rtl/utf8_validate_sanitize_stream.sv */
// ----------------------------------------------------------------------------
// utf8_validate_sanitize_stream
// Byte-stream sanitizer with size, line and UTF-8 checks per string.
// ----------------------------------------------------------------------------
// One byte enters per clock into the input register, and its sanitized
// copy moves on into the result register when that is empty or read;
// a new item is taken in every cycle as long as the output side takes
// results. The rate is set by the single state update per byte (counters and
// decoder) that sits between the input register and the result register.
// The verdict appears on the result of the byte marked tlast and is zero on
// all other results.
module utf8_validate_sanitize_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_byte[7:0], base_size[39:8]
	input  logic        s_tlast,   // last_of_string
	input  logic [0:0]  s_tuser,   // first_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // clean_byte[7:0], verdict[10:8], zero[15:11]
	output logic        m_tlast    // end_of_string
);

	localparam int CW = utf8vs_pkg::CNT_W;
	localparam int SW = utf8vs_pkg::SUM_W;

	// configuration
	logic [31:0] max_total_q;
	logic [31:0] max_lines_q;
	logic        strict_q;
	logic        allow_ctrl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q  <= 32'd1048576;
			max_lines_q  <= 32'd100000;
			strict_q     <= 1'b1;
			allow_ctrl_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				utf8vs_pkg::CFG_MAX_TOTAL:  max_total_q  <= cfg_data;
				utf8vs_pkg::CFG_MAX_LINES:  max_lines_q  <= cfg_data;
				utf8vs_pkg::CFG_STRICT:     strict_q     <= cfg_data[0];
				utf8vs_pkg::CFG_ALLOW_CTRL: allow_ctrl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic [31:0] base_s1;
	logic        valid_s2;
	logic        adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[7:0];
			base_s1  <= s_tdata[39:8];
			first_s1 <= s_tuser[0];
			last_s1  <= s_tlast;
		end
	end

	// string state
	logic [CW-1:0]              bytes_q;
	logic [CW-1:0]              lines_q;
	logic [SW-1:0]              sum_q;
	logic [1:0]                 expect_q;
	utf8vs_pkg::flaw_t          flaw_q;
	logic [7:0]                 lead_q;
	utf8vs_pkg::verdict_t       err_q;

	logic [CW-1:0]              bytes_e, bytes_n, lines_e, lines_n;
	logic [SW-1:0]              sum_e, sum_n;
	logic [1:0]                 expect_e, expect_n;
	utf8vs_pkg::flaw_t          flaw_e, flaw_n;
	logic [7:0]                 lead_e, lead_n;
	utf8vs_pkg::verdict_t       err_e, err_n, verdict;
	logic                       first_pos, size_bad, lines_bad;

	always_comb begin
		bytes_e  = first_s1 ? '0 : bytes_q;
		lines_e  = first_s1 ? '0 : lines_q;
		sum_e    = first_s1 ? SW'(base_s1) : sum_q;
		expect_e = first_s1 ? 2'd0 : expect_q;
		flaw_e   = first_s1 ? utf8vs_pkg::FLAW_NONE : flaw_q;
		lead_e   = first_s1 ? 8'd0 : lead_q;
		err_e    = first_s1 ? utf8vs_pkg::VERD_OK : err_q;

		bytes_n = bytes_e + CW'(bytes_e != utf8vs_pkg::CNT_CEIL);
		sum_n   = sum_e + SW'(bytes_e != utf8vs_pkg::CNT_CEIL);
		lines_n = lines_e + CW'(byte_s1 == utf8vs_pkg::CH_LF
			&& lines_e != utf8vs_pkg::CNT_CEIL);

		expect_n = expect_e;
		flaw_n   = flaw_e;
		lead_n   = lead_e;
		err_n    = err_e;

		first_pos = (lead_e[7:5] == 3'b110 && expect_e == 2'd1)
			|| (lead_e[7:4] == 4'b1110 && expect_e == 2'd2)
			|| (lead_e[7:3] == 5'b11110 && expect_e == 2'd3);

		if (expect_e == 2'd0) begin
			if (byte_s1[7]) begin
				if (byte_s1[7:5] == 3'b110) begin
					expect_n = 2'd1;
					lead_n   = byte_s1;
					flaw_n   = (byte_s1 <= utf8vs_pkg::LEAD_C1) ?
						utf8vs_pkg::FLAW_OVERLONG : utf8vs_pkg::FLAW_NONE;
				end else if (byte_s1[7:4] == 4'b1110) begin
					expect_n = 2'd2;
					lead_n   = byte_s1;
					flaw_n   = utf8vs_pkg::FLAW_NONE;
				end else if (byte_s1[7:3] == 5'b11110) begin
					expect_n = 2'd3;
					lead_n   = byte_s1;
					flaw_n   = (byte_s1 > utf8vs_pkg::LEAD_F4) ?
						utf8vs_pkg::FLAW_RANGE : utf8vs_pkg::FLAW_NONE;
				end else if (err_n == utf8vs_pkg::VERD_OK) begin
					err_n = utf8vs_pkg::VERD_BADLEAD;
				end
			end
		end else begin
			if (byte_s1[7:6] != 2'b10) begin
				flaw_n = utf8vs_pkg::FLAW_BADCONT;
			end else if (flaw_e == utf8vs_pkg::FLAW_NONE && first_pos) begin
				if (lead_e == utf8vs_pkg::LEAD_E0 && byte_s1 < utf8vs_pkg::CONT_A0) begin
					flaw_n = utf8vs_pkg::FLAW_OVERLONG;
				end else if (lead_e == utf8vs_pkg::LEAD_F0
						&& byte_s1 < utf8vs_pkg::CONT_90) begin
					flaw_n = utf8vs_pkg::FLAW_OVERLONG;
				end else if (lead_e == utf8vs_pkg::LEAD_F4
						&& byte_s1 > utf8vs_pkg::CONT_8F) begin
					flaw_n = utf8vs_pkg::FLAW_RANGE;
				end
			end
			expect_n = expect_e - 2'd1;
			if (expect_n == 2'd0) begin
				if (err_n == utf8vs_pkg::VERD_OK) begin
					case (flaw_n)
						utf8vs_pkg::FLAW_BADCONT:  err_n = utf8vs_pkg::VERD_BADCONT;
						utf8vs_pkg::FLAW_OVERLONG: err_n = utf8vs_pkg::VERD_OVERLONG;
						utf8vs_pkg::FLAW_RANGE:    err_n = utf8vs_pkg::VERD_RANGE;
						default:                   err_n = utf8vs_pkg::VERD_OK;
					endcase
				end
				flaw_n = utf8vs_pkg::FLAW_NONE;
			end
		end

		if (last_s1 && expect_n != 2'd0 && err_n == utf8vs_pkg::VERD_OK) begin
			err_n = utf8vs_pkg::VERD_TRUNC;
		end

		size_bad  = (bytes_n == utf8vs_pkg::CNT_CEIL) || (sum_n > SW'(max_total_q));
		lines_bad = (lines_n == utf8vs_pkg::CNT_CEIL) || (SW'(lines_n) > SW'(max_lines_q));

		if (!last_s1) begin
			verdict = utf8vs_pkg::VERD_OK;
		end else if (size_bad) begin
			verdict = utf8vs_pkg::VERD_SIZE;
		end else if (strict_q && err_n != utf8vs_pkg::VERD_OK) begin
			verdict = err_n;
		end else if (lines_bad) begin
			verdict = utf8vs_pkg::VERD_LINES;
		end else begin
			verdict = utf8vs_pkg::VERD_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q  <= '0;
			lines_q  <= '0;
			sum_q    <= '0;
			expect_q <= 2'd0;
			flaw_q   <= utf8vs_pkg::FLAW_NONE;
			lead_q   <= 8'd0;
			err_q    <= utf8vs_pkg::VERD_OK;
		end else if (adv) begin
			bytes_q  <= bytes_n;
			lines_q  <= lines_n;
			sum_q    <= sum_n;
			expect_q <= expect_n;
			flaw_q   <= flaw_n;
			lead_q   <= lead_n;
			err_q    <= err_n;
		end
	end

	// result register
	logic [7:0]           clean_s2;
	utf8vs_pkg::verdict_t verdict_s2;
	logic                 last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clean_s2   <= utf8vs_pkg::sanitize(byte_s1, allow_ctrl_q);
			verdict_s2 <= verdict;
			last_s2    <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, verdict_s2, clean_s2};
	assign m_tlast  = last_s2;

endmodule
